// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL (included by trpn_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/trpn_pkg.sv =====
// ----------------------------------------------------------------------------
// trpn_pkg
// Shared types and constants of the typed postfix expression evaluator.
// ----------------------------------------------------------------------------
package trpn_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH     = 4;

   // operand type codes
   localparam logic [2:0] TY_NULL = 3'd0;
   localparam logic [2:0] TY_BOOL = 3'd1;
   localparam logic [2:0] TY_INT  = 3'd2;
   localparam logic [2:0] TY_REAL = 3'd3;
   localparam logic [2:0] TY_STR  = 3'd4;

   // error flag bit positions
   localparam int FL_TYPE  = 0;
   localparam int FL_DIV0  = 1;
   localparam int FL_NULL  = 2;
   localparam int FL_FAULT = 3;

   typedef enum logic [4:0] {
      OP_ADD         = 5'd0,
      OP_SUB         = 5'd1,
      OP_MUL         = 5'd2,
      OP_DIV         = 5'd3,
      OP_MOD         = 5'd4,
      OP_LT          = 5'd5,
      OP_GT          = 5'd6,
      OP_LTE         = 5'd7,
      OP_GTE         = 5'd8,
      OP_EQ          = 5'd9,
      OP_NE          = 5'd10,
      OP_AND         = 5'd11,
      OP_OR          = 5'd12,
      OP_NEG         = 5'd13,
      OP_NOT         = 5'd14,
      OP_LIT_BOOL    = 5'd15,
      OP_LIT_INT     = 5'd16,
      OP_LIT_REAL    = 5'd17,
      OP_LIT_STR     = 5'd18,
      OP_FIELD_LEFT  = 5'd19,
      OP_FIELD_RIGHT = 5'd20,
      OP_LEFT_BEGIN  = 5'd21,
      OP_LEFT_END    = 5'd22,
      OP_RIGHT_BEGIN = 5'd23,
      OP_RIGHT_END   = 5'd24
   } opcode_type;

   // classified token handed from front to back
   typedef struct packed {
      logic [4:0]  op;
      logic [1:0]  npop;
      logic        push_lit;
      logic [2:0]  ptype;
      logic [63:0] pval;
      logic        null_f;
      logic        last;
   } tok_type;

endpackage

// ===== design/trpn_if.sv =====
// ----------------------------------------------------------------------------
// trpn_req_if / trpn_rsp_if
// Valid/ready channels carrying tokens in and results out.
// ----------------------------------------------------------------------------
interface trpn_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  opcode;
   logic [2:0]  operand_type;
   logic [63:0] operand_value;
   logic        last_token;

   modport source (output valid, opcode, operand_type, operand_value, last_token,
                   input ready);
   modport sink   (input valid, opcode, operand_type, operand_value, last_token,
                   output ready);
endinterface

interface trpn_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_type;
   logic [63:0] result_value;
   logic        type_error;
   logic        divide_by_zero;
   logic        null_operand;
   logic        stack_fault;

   modport source (output valid, result_type, result_value, type_error,
                   divide_by_zero, null_operand, stack_fault, input ready);
   modport sink   (input valid, result_type, result_value, type_error,
                   divide_by_zero, null_operand, stack_fault, output ready);
endinterface

// ===== design/trpn_front.sv =====
// ----------------------------------------------------------------------------
// trpn_front
// Accepts tokens and classifies them: pop count, literal normalization.
// ----------------------------------------------------------------------------
module trpn_front
   import trpn_pkg::*;
(
   trpn_req_if.sink  req,
   input  logic      q_full,
   output logic      q_push,
   output tok_type   q_tok
);

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_tok          = '0;
      q_tok.op       = req.opcode;
      q_tok.last     = req.last_token;
      q_tok.pval     = req.operand_value;
      case (req.opcode)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_LTE, OP_GTE,
         OP_EQ, OP_NE, OP_AND, OP_OR: begin
            q_tok.npop = 2'd2;
         end
         OP_NEG, OP_NOT: begin
            q_tok.npop = 2'd1;
         end
         OP_LIT_BOOL: begin
            q_tok.push_lit = 1'b1;
            q_tok.ptype    = TY_BOOL;
            q_tok.pval     = {63'd0, |req.operand_value};
         end
         OP_LIT_INT, OP_LEFT_BEGIN, OP_LEFT_END, OP_RIGHT_BEGIN, OP_RIGHT_END: begin
            q_tok.push_lit = 1'b1;
            q_tok.ptype    = TY_INT;
         end
         OP_LIT_REAL: begin
            q_tok.push_lit = 1'b1;
            q_tok.ptype    = TY_REAL;
         end
         OP_LIT_STR: begin
            q_tok.push_lit = 1'b1;
            q_tok.ptype    = TY_STR;
         end
         OP_FIELD_LEFT, OP_FIELD_RIGHT: begin
            q_tok.push_lit = 1'b1;
            if (req.operand_type == TY_NULL || req.operand_type > TY_STR) begin
               q_tok.ptype  = TY_NULL;
               q_tok.pval   = '0;
               q_tok.null_f = 1'b1;
            end else if (req.operand_type == TY_BOOL) begin
               q_tok.ptype = TY_BOOL;
               q_tok.pval  = {63'd0, |req.operand_value};
            end else begin
               q_tok.ptype = req.operand_type;
            end
         end
         default: begin
            q_tok.npop = 2'd0;   // unused codes do nothing
         end
      endcase
   end

endmodule

// ===== design/trpn_queue.sv =====
// ----------------------------------------------------------------------------
// trpn_queue
// Short token queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module trpn_queue
   import trpn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  tok_type push_tok,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output tok_type pop_tok
);

   localparam int QIW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   tok_type         slot_ff [QUEUE_DEPTH];
   logic [QIW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCW-1:0]  cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full    = (cnt_ff == QCW'(QUEUE_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign pop_tok = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = (do_push) ? ((wr_ff == QIW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = (do_pop)  ? ((rd_ff == QIW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + QCW'(do_push) - QCW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_tok;
      end
   end

endmodule

// ===== design/trpn_mul.sv =====
// ----------------------------------------------------------------------------
// trpn_mul
// 64x64 unsigned multiplier built from four 32x32 partial products in turn.
// ----------------------------------------------------------------------------
module trpn_mul (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   output logic          done,
   output logic [127:0]  prod
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   sh_ff, sh_in;
   logic         pv_ff, pv_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         run_ff, run_in;
   logic         done_ff, done_in;
   logic [127:0] acc_ff, acc_in;
   logic [127:0] pp_pos;
   logic [31:0]  xs, ys;

   assign done = done_ff;
   assign prod = acc_ff;

   always_comb begin
      xs = cnt_ff[0] ? a_ff[63:32] : a_ff[31:0];
      ys = cnt_ff[1] ? b_ff[63:32] : b_ff[31:0];
      case (sh_ff)
         2'd0:    pp_pos = {64'd0, pp_ff};
         2'd1:    pp_pos = {32'd0, pp_ff, 32'd0};
         default: pp_pos = {pp_ff, 64'd0};
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      pv_in   = 1'b0;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      if (start) begin
         a_in   = a;
         b_in   = b;
         cnt_in = '0;
         run_in = 1'b1;
         acc_in = '0;
      end else if (run_ff) begin
         if (pv_ff) begin
            acc_in = acc_ff + pp_pos;
         end
         if (cnt_ff != 3'd4) begin
            pp_in  = xs * ys;
            sh_in  = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
            pv_in  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end else if (pv_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         pv_ff   <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         pv_ff   <= pv_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
   end

endmodule

// ===== design/trpn_div.sv =====
// ----------------------------------------------------------------------------
// trpn_div
// Restoring divider, 128-bit dividend by 64-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module trpn_div (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [127:0]  dividend,
   input  logic [63:0]   divisor,
   output logic          done,
   output logic [127:0]  quo,
   output logic [63:0]   rem
);

   logic [127:0] dvd_ff, dvd_in;
   logic [63:0]  rem_ff, rem_in, d_ff, d_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         run_ff, run_in, done_ff, done_in;
   logic [64:0]  rs, diff;
   logic         ge;

   assign done = done_ff;
   assign quo  = dvd_ff;
   assign rem  = rem_ff;

   always_comb begin
      rs      = {rem_ff, dvd_ff[127]};
      diff    = rs - {1'b0, d_ff};
      ge      = (rs >= {1'b0, d_ff});
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         d_in   = divisor;
         cnt_in = 7'd127;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[63:0] : rs[63:0];
         dvd_in = {dvd_ff[126:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

endmodule

// ===== design/trpn_back.sv =====
// ----------------------------------------------------------------------------
// trpn_back
// Executes classified tokens on the typed operand stack; emits results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trpn_back
   import trpn_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  tok_type    q_tok,
   output logic       q_pop,
   trpn_rsp_if.source rsp
);

   localparam int IW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam logic signed [63:0] R_INT_MAX = 64'sd549755813887;
   localparam logic signed [63:0] R_INT_MIN = -R_INT_MAX - 64'sd1;
   localparam logic [63:0] V_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] V_MIN = {1'b1, 63'd0};
   localparam logic [127:0] HALF_LSB = 128'd1 << 23;

   typedef struct packed {
      logic [2:0]  t;
      logic [63:0] v;
   } entry_type;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_POP  = 10'b0000000010,
      S_CAP  = 10'b0000000100,
      S_EXEC = 10'b0000001000,
      S_MUL  = 10'b0000010000,
      S_DIV  = 10'b0000100000,
      S_FIN  = 10'b0001000000,
      S_OUT  = 10'b0010000000
   } state_type;

   state_type        state_ff, state_in;
   tok_type          tok_ff, tok_in;
   entry_type        l_ff, l_in, r_ff, r_in;
   entry_type        stk_mem [STACK_DEPTH];
   entry_type        rd_data_ff, popped;
   logic [SPW-1:0]   sp_ff, sp_in, sp_dec;
   logic [IW-1:0]    rd_idx, wr_idx;
   logic [1:0]       npop_ff, npop_in;
   logic             final_ff, final_in, und_ff, und_in;
   logic [3:0]       err_ff, err_in;
   logic [127:0]     mag_ff, mag_in, rnd;
   logic             neg_ff, neg_in, sat_ff, sat_in, mod_ff, mod_in, round_ff, round_in;
   logic [2:0]       rtype_ff, rtype_in;
   logic             out_valid_ff, out_load;
   entry_type        out_ff;
   logic [3:0]       out_err_ff;
   // execute-step decisions
   logic             ex_push, ex_mul, ex_div;
   entry_type        ex_res;
   logic [3:0]       ex_err;
   logic             ex_neg, ex_sat, ex_mod, ex_round;
   logic [2:0]       ex_rtype;
   logic [127:0]     ex_dvd;
   logic             lnum, rnum, ints, lreal, rreal;
   logic [1:0]       cmp, cmp_sw;
   logic             eqv;
   logic [63:0]      lmag, rmag;
   // push port
   logic             push_en, mem_we;
   entry_type        push_e, fin_e;
   logic             step_done;
   logic             mul_done, div_done;
   logic [127:0]     mul_prod, div_quo;
   logic [63:0]      div_rem;

   function automatic logic [63:0] to_real(input logic signed [63:0] i);
      if (i > R_INT_MAX) begin
         return V_MAX;
      end else if (i < R_INT_MIN) begin
         return V_MIN;
      end
      return {i[39:0], 24'd0};
   endfunction

   function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                           input logic sub);
      logic [63:0] s;
      logic        ovf;
      s   = sub ? a - b : a + b;
      ovf = (sub ? (a[63] != b[63]) : (a[63] == b[63])) && (s[63] != a[63]);
      if (ovf) begin
         return a[63] ? V_MIN : V_MAX;
      end
      return s;
   endfunction

   // {less, greater} of integer i against Q40.24 real r
   function automatic logic [1:0] cmp_ir(input logic signed [63:0] i,
                                         input logic signed [63:0] r);
      logic signed [63:0] fl;
      fl = r >>> 24;
      if (i < fl) begin
         return 2'b10;
      end else if (i > fl) begin
         return 2'b01;
      end
      return (r[23:0] != '0) ? 2'b10 : 2'b00;
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] x);
      return x[63] ? -x : x;
   endfunction

   // ---------------------------------------------------------------- operands
   always_comb begin
      lreal  = (l_ff.t == TY_REAL);
      rreal  = (r_ff.t == TY_REAL);
      lnum   = (l_ff.t == TY_INT) || lreal;
      rnum   = (r_ff.t == TY_INT) || rreal;
      ints   = (l_ff.t == TY_INT) && (r_ff.t == TY_INT);
      lmag   = mag64(l_ff.v);
      rmag   = mag64(r_ff.v);
      cmp_sw = cmp_ir(r_ff.v, l_ff.v);
      if (l_ff.t == r_ff.t) begin
         cmp = {($signed(l_ff.v) < $signed(r_ff.v)), ($signed(l_ff.v) > $signed(r_ff.v))};
      end else if (l_ff.t == TY_INT) begin
         cmp = cmp_ir(l_ff.v, r_ff.v);
      end else begin
         cmp = {cmp_sw[0], cmp_sw[1]};
      end
      eqv = (cmp == 2'b00);
   end

   // ---------------------------------------------------------------- execute
   always_comb begin
      ex_push  = 1'b1;
      ex_mul   = 1'b0;
      ex_div   = 1'b0;
      ex_res   = '{t: TY_INT, v: '0};
      ex_err   = '0;
      ex_neg   = l_ff.v[63] ^ r_ff.v[63];
      ex_sat   = !ints;
      ex_mod   = 1'b0;
      ex_round = lreal && rreal;
      ex_rtype = ints ? TY_INT : TY_REAL;
      ex_dvd   = {64'd0, lmag};
      case (tok_ff.op)
         OP_ADD, OP_SUB: begin
            if (!(lnum && rnum)) begin
               ex_err[FL_TYPE] = 1'b1;
            end else if (ints) begin
               ex_res.v = (tok_ff.op == OP_SUB) ? l_ff.v - r_ff.v : l_ff.v + r_ff.v;
            end else begin
               ex_res.t = TY_REAL;
               ex_res.v = sat_sum(lreal ? l_ff.v : to_real(l_ff.v),
                                  rreal ? r_ff.v : to_real(r_ff.v), tok_ff.op == OP_SUB);
            end
         end
         OP_MUL: begin
            if (!(lnum && rnum)) begin
               ex_err[FL_TYPE] = 1'b1;
            end else begin
               ex_push = 1'b0;
               ex_mul  = 1'b1;
            end
         end
         OP_DIV: begin
            if (!(lnum && rnum)) begin
               ex_err[FL_TYPE] = 1'b1;
            end else if (r_ff.v == '0) begin
               ex_err[FL_DIV0] = 1'b1;
               ex_res.t        = ex_rtype;
            end else begin
               ex_push = 1'b0;
               ex_div  = 1'b1;
               if (lreal && rreal) begin
                  ex_dvd = {40'd0, lmag, 24'd0};
               end else if (!lreal && rreal) begin
                  ex_dvd = {16'd0, lmag, 48'd0};
               end
            end
         end
         OP_MOD: begin
            if (!ints) begin
               ex_err[FL_TYPE] = 1'b1;
            end else if (r_ff.v == '0) begin
               ex_err[FL_DIV0] = 1'b1;
            end else begin
               ex_push = 1'b0;
               ex_div  = 1'b1;
               ex_mod  = 1'b1;
               ex_neg  = l_ff.v[63];
               ex_sat  = 1'b0;
            end
         end
         OP_LT, OP_GT, OP_LTE, OP_GTE: begin
            ex_res.t = TY_BOOL;
            if (lnum && rnum) begin
               case (tok_ff.op)
                  OP_LT:   ex_res.v[0] = cmp[1];
                  OP_GT:   ex_res.v[0] = cmp[0];
                  OP_LTE:  ex_res.v[0] = !cmp[0];
                  default: ex_res.v[0] = !cmp[1];
               endcase
            end else begin
               ex_err[FL_TYPE] = 1'b1;
            end
         end
         OP_EQ, OP_NE: begin
            ex_res.t = TY_BOOL;
            if (lnum && rnum) begin
               ex_res.v[0] = (tok_ff.op == OP_EQ) ? eqv : !eqv;
            end else if ((l_ff.t == TY_STR && r_ff.t == TY_STR) ||
                         (l_ff.t == TY_BOOL && r_ff.t == TY_BOOL)) begin
               ex_res.v[0] = (tok_ff.op == OP_EQ) ? (l_ff.v == r_ff.v) : (l_ff.v != r_ff.v);
            end else begin
               ex_err[FL_TYPE] = 1'b1;
            end
         end
         OP_AND, OP_OR: begin
            ex_res.t = TY_BOOL;
            if (l_ff.t == TY_BOOL && r_ff.t == TY_BOOL) begin
               ex_res.v[0] = (tok_ff.op == OP_AND) ? (|l_ff.v && |r_ff.v)
                                                   : (|l_ff.v || |r_ff.v);
            end else begin
               ex_err[FL_TYPE] = 1'b1;
            end
         end
         OP_NEG: begin
            if (l_ff.t == TY_INT) begin
               ex_res.v = -l_ff.v;
            end else if (lreal) begin
               ex_res.t = TY_REAL;
               ex_res.v = (l_ff.v == V_MIN) ? V_MAX : -l_ff.v;
            end else begin
               ex_err[FL_TYPE] = 1'b1;
            end
         end
         OP_NOT: begin
            ex_res.t = TY_BOOL;
            if (l_ff.t == TY_BOOL) begin
               ex_res.v[0] = !(|l_ff.v);
            end else begin
               ex_err[FL_TYPE] = 1'b1;
            end
         end
         default: begin
            // pushes and unused codes
            ex_push         = tok_ff.push_lit;
            ex_res          = '{t: tok_ff.ptype, v: tok_ff.pval};
            ex_err[FL_NULL] = tok_ff.null_f;
         end
      endcase
   end

   // --------------------------------------------------- finish wide results
   always_comb begin
      fin_e.t = rtype_ff;
      if (!sat_ff) begin
         fin_e.v = neg_ff ? -mag_ff[63:0] : mag_ff[63:0];
      end else if (neg_ff) begin
         fin_e.v = (mag_ff[127:64] != '0 || mag_ff[63:0] > V_MIN) ? V_MIN : -mag_ff[63:0];
      end else begin
         fin_e.v = (mag_ff[127:64] != '0 || mag_ff[63]) ? V_MAX : mag_ff[63:0];
      end
      rnd = mul_prod + HALF_LSB;
   end

   // ------------------------------------------------------------ sequencer
   assign sp_dec    = sp_ff - 1'b1;
   assign rd_idx    = sp_dec[IW-1:0];
   assign wr_idx    = sp_ff[IW-1:0];
   assign popped    = und_ff ? '{t: TY_NULL, v: '0} : rd_data_ff;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign out_load  = (state_ff == S_OUT) && (!out_valid_ff || rsp.ready);
   assign step_done = ((state_ff == S_EXEC) && !ex_mul && !ex_div) || (state_ff == S_FIN);
   assign push_en   = ((state_ff == S_EXEC) && ex_push) || (state_ff == S_FIN);
   assign push_e    = (state_ff == S_FIN) ? fin_e : ex_res;
   assign mem_we    = push_en && (sp_ff < SPW'(STACK_DEPTH));

   always_comb begin
      state_in = state_ff;
      tok_in   = tok_ff;
      l_in     = l_ff;
      r_in     = r_ff;
      sp_in    = sp_ff;
      npop_in  = npop_ff;
      final_in = final_ff;
      und_in   = und_ff;
      err_in   = err_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      mod_in   = mod_ff;
      round_in = round_ff;
      rtype_in = rtype_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               tok_in   = q_tok;
               npop_in  = q_tok.npop;
               state_in = (q_tok.npop != '0) ? S_POP : S_EXEC;
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               und_in           = 1'b1;
               err_in[FL_FAULT] = 1'b1;
            end else begin
               und_in = 1'b0;
               sp_in  = sp_dec;
            end
            state_in = S_CAP;
         end
         S_CAP: begin
            l_in    = popped;
            r_in    = l_ff;
            npop_in = npop_ff - 1'b1;
            if (npop_ff != 2'd1) begin
               state_in = S_POP;
            end else begin
               state_in = final_ff ? S_OUT : S_EXEC;
            end
         end
         S_EXEC: begin
            err_in   = err_ff | ex_err;
            neg_in   = ex_neg;
            sat_in   = ex_sat;
            mod_in   = ex_mod;
            round_in = ex_round;
            rtype_in = ex_rtype;
            if (ex_mul) begin
               state_in = S_MUL;
            end else if (ex_div) begin
               state_in = S_DIV;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               mag_in   = round_ff ? {24'd0, rnd[127:24]} : mul_prod;
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            if (div_done) begin
               mag_in   = mod_ff ? {64'd0, div_rem} : div_quo;
               state_in = S_FIN;
            end
         end
         S_OUT: begin
            if (out_load) begin
               sp_in    = '0;
               err_in   = '0;
               final_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // push, then either pop the result or wait for the next token
      if (push_en) begin
         if (mem_we) begin
            sp_in = sp_ff + 1'b1;
         end else begin
            err_in[FL_FAULT] = 1'b1;
         end
      end
      if (step_done) begin
         if (tok_ff.last) begin
            final_in = 1'b1;
            npop_in  = 2'd1;
            state_in = S_POP;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         err_ff       <= '0;
         final_ff     <= 1'b0;
         npop_ff      <= '0;
         und_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         err_ff   <= err_in;
         final_ff <= final_in;
         npop_ff  <= npop_in;
         und_ff   <= und_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_ff   <= tok_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      sat_ff   <= sat_in;
      mod_ff   <= mod_in;
      round_ff <= round_in;
      rtype_ff <= rtype_in;
      if (out_load) begin
         out_ff.t   <= l_ff.t;
         out_ff.v   <= (l_ff.t == TY_NULL) ? '0 : l_ff.v;
         out_err_ff <= err_ff;
      end
   end

   // operand stack storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stk_mem[wr_idx] <= push_e;
      end
      rd_data_ff <= stk_mem[rd_idx];
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.result_type    = out_ff.t;
   assign rsp.result_value   = out_ff.v;
   assign rsp.type_error     = out_err_ff[FL_TYPE];
   assign rsp.divide_by_zero = out_err_ff[FL_DIV0];
   assign rsp.null_operand   = out_err_ff[FL_NULL];
   assign rsp.stack_fault    = out_err_ff[FL_FAULT];

   trpn_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start ((state_ff == S_EXEC) && ex_mul),
      .a     (lmag),
      .b     (rmag),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   trpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == S_EXEC) && ex_div),
      .dividend (ex_dvd),
      .divisor  (rmag),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   `ASSERT_ALWAYS(a_sp_bound, clock, reset, sp_ff <= SPW'(STACK_DEPTH))
   `ASSERT_NEXT(a_emit_clears, clock, reset, out_load, (sp_ff == '0) && (err_ff == '0))
   `ASSERT_IMPLY(a_mul_owner, clock, reset, mul_done, state_ff == S_MUL)
   `ASSERT_IMPLY(a_div_owner, clock, reset, div_done, state_ff == S_DIV)

endmodule

// ===== design/typed_rpn_expression_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// typed_rpn_expression_evaluator_unit
// Typed postfix expression evaluator: tokens in, one result per expression.
// ----------------------------------------------------------------------------
//   channel | dir | beat carries
//   --------+-----+----------------------------------------------------------
//   req     | in  | opcode, operand_type, operand_value, last_token
//   rsp     | out | result_type, result_value, type_error, divide_by_zero,
//           |     | null_operand, stack_fault
//
// Sequencing: the back executes one token at a time; a push passes through
//   idle and execute, each popped operand adds a pop and a capture state;
//   add, compare and logic finish in the execute state, multiply builds four
//   32x32 partial products, divide and remainder one quotient bit per cycle.
//   The final token adds a pop, a capture and an output step.
// Reset: synchronous; empties the stack and clears flags, queue and rsp valid.
// Stalls: the front keeps taking beats while the token queue has room; a
//   result held in the output register only blocks the next result.
// ----------------------------------------------------------------------------
module typed_rpn_expression_evaluator_unit
   import trpn_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   trpn_req_if.sink   req_chan,
   trpn_rsp_if.source rsp_chan
);

   // front -> queue
   logic    q_push, q_full;
   tok_type q_in_tok;
   // queue -> back
   logic    q_valid, q_pop;
   tok_type q_out_tok;

   // classify tokens as they arrive
   trpn_front u_front (
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_tok  (q_in_tok)
   );

   // hold classified tokens so the front and back stall independently
   trpn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_tok (q_in_tok),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_tok  (q_out_tok)
   );

   // stack machine, arithmetic units and output register
   trpn_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_tok   (q_out_tok),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the typed postfix expression evaluator. Directed
// tokens cover the edge cases, then random expressions follow. A typed stack
// model tracks every token accepted and predicts each popped result. Both
// channels stall at random.
// ----------------------------------------------------------------------------
module tb_top
   import trpn_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  DEPTH        = STACK_DEPTH_DEF;
   localparam int  RANDOM_ITEMS = 1700;
   localparam logic [4:0] OP_SPARE_LO = 5'd25;   // first opcode with no effect
   localparam logic [4:0] OP_SPARE_HI = 5'd31;
   localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SMIN = 64'sh8000_0000_0000_0000;
   localparam longint REAL_ONE_HALF = 64'sh180_0000;   // 1.5 in Q40.24

   // one result beat as the block reports it
   typedef struct packed {
      logic [2:0]  rtype;
      logic [63:0] rvalue;
      logic        type_err;
      logic        div_zero;
      logic        null_op;
      logic        fault;
   } beat_type;

   // one row of the directed token table
   typedef struct {
      logic [4:0] op;
      logic [2:0] otype;
      longint     oval;
      bit         last;
      bit         typed;      // expected result written in the row
      beat_type   exp;
   } token_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   trpn_req_if req_if();
   trpn_rsp_if rsp_if();

   typed_rpn_expression_evaluator_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Stack model: its own copy of the operand stack and the error flags.
   // ---------------------------------------------------------------------
   longint     mdl_val [DEPTH];
   logic [2:0] mdl_ty  [DEPTH];
   int         mdl_sp;
   bit         f_type, f_div0, f_null, f_fault;

   beat_type pending_results[$];
   int       mismatch_count;
   bit       fail_seen;
   bit       burst_mode;

   function automatic void mdl_push(logic [2:0] t, longint v);
      if (mdl_sp >= DEPTH) begin
         f_fault = 1'b1;
         return;
      end
      mdl_ty[mdl_sp]  = t;
      mdl_val[mdl_sp] = v;
      mdl_sp++;
   endfunction

   function automatic void mdl_pop(output logic [2:0] t, output longint v);
      if (mdl_sp == 0) begin
         f_fault = 1'b1;
         t = TY_NULL;
         v = 0;
         return;
      end
      mdl_sp--;
      t = mdl_ty[mdl_sp];
      v = mdl_val[mdl_sp];
   endfunction

   function automatic logic [63:0] magnitude(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint sat_mag(logic [127:0] m, bit neg);
      if (neg) begin
         if (m > 128'h8000_0000_0000_0000) return SMIN;
         return longint'(-m[63:0]);
      end
      if (m > 128'h7FFF_FFFF_FFFF_FFFF) return SMAX;
      return longint'(m[63:0]);
   endfunction

   function automatic longint int_to_q24(longint i);
      if (i > 64'sd549755813887) return SMAX;
      if (i < -64'sd549755813888) return SMIN;
      return i <<< 24;
   endfunction

   function automatic longint sat_sum(longint a, longint b, bit subtract);
      longint s;
      s = subtract ? a - b : a + b;
      if (((a < 0) == ((b < 0) ^ subtract)) && ((s < 0) != (a < 0)))
         return a < 0 ? SMIN : SMAX;
      // subtracting zero never overflows; the check above lets it through too
      if (subtract && b == 0) return a;
      return s;
   endfunction

   function automatic longint q_mul(longint a, longint b, int shift);
      logic [127:0] m;
      m = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      if (shift != 0) m = (m + (128'd1 << (shift - 1))) >> shift;
      return sat_mag(m, (a < 0) != (b < 0));
   endfunction

   function automatic longint q_div(longint a, longint b, int shift);
      logic [127:0] n;
      n = {64'd0, magnitude(a)} << shift;
      return sat_mag(n / {64'd0, magnitude(b)}, (a < 0) != (b < 0));
   endfunction

   // exact three-way compare of an integer with a Q40.24 real
   function automatic int cmp_int_q24(longint i, longint r);
      longint fl;
      fl = r >>> 24;
      if (i < fl) return -1;
      if (i > fl) return 1;
      return r[23:0] != 0 ? -1 : 0;
   endfunction

   function automatic int num_order(logic [2:0] lt, longint lv, logic [2:0] rt, longint rv);
      if (lt == rt) return lv < rv ? -1 : (lv > rv ? 1 : 0);
      if (lt == TY_INT) return cmp_int_q24(lv, rv);
      return -cmp_int_q24(rv, lv);
   endfunction

   function automatic bit is_num(logic [2:0] t);
      return t == TY_INT || t == TY_REAL;
   endfunction

   function automatic void eval_arith(logic [4:0] op, logic [2:0] lt, longint lv,
                                      logic [2:0] rt, longint rv);
      bit ints;
      ints = (lt == TY_INT) && (rt == TY_INT);
      if (op == OP_MOD) begin
         if (!ints) begin f_type = 1'b1; mdl_push(TY_INT, 0); end
         else if (rv == 0) begin f_div0 = 1'b1; mdl_push(TY_INT, 0); end
         else mdl_push(TY_INT, rv == -1 ? 0 : lv % rv);
         return;
      end
      if (!is_num(lt) || !is_num(rt)) begin
         f_type = 1'b1;
         mdl_push(TY_INT, 0);
         return;
      end
      if (ints) begin
         case (op)
            OP_ADD: mdl_push(TY_INT, lv + rv);
            OP_SUB: mdl_push(TY_INT, lv - rv);
            OP_MUL: mdl_push(TY_INT, lv * rv);
            default: begin
               if (rv == 0) begin f_div0 = 1'b1; mdl_push(TY_INT, 0); end
               else if (rv == -1) mdl_push(TY_INT, -lv);
               else mdl_push(TY_INT, lv / rv);
            end
         endcase
         return;
      end
      case (op)
         OP_ADD: mdl_push(TY_REAL, sat_sum(lt == TY_INT ? int_to_q24(lv) : lv,
                                           rt == TY_INT ? int_to_q24(rv) : rv, 1'b0));
         OP_SUB: mdl_push(TY_REAL, sat_sum(lt == TY_INT ? int_to_q24(lv) : lv,
                                           rt == TY_INT ? int_to_q24(rv) : rv, 1'b1));
         OP_MUL: mdl_push(TY_REAL, q_mul(lv, rv, (lt == TY_REAL && rt == TY_REAL) ? 24 : 0));
         default: begin
            if (rv == 0) begin f_div0 = 1'b1; mdl_push(TY_REAL, 0); end
            else if (lt == TY_REAL && rt == TY_REAL) mdl_push(TY_REAL, q_div(lv, rv, 24));
            else if (lt == TY_REAL) mdl_push(TY_REAL, q_div(lv, rv, 0));
            else mdl_push(TY_REAL, q_div(lv, rv, 48));
         end
      endcase
   endfunction

   function automatic void eval_compare(logic [4:0] op, logic [2:0] lt, longint lv,
                                        logic [2:0] rt, longint rv);
      bit res, ok, same;
      int c;
      res = 1'b0;
      if (op <= OP_GTE) begin
         if (is_num(lt) && is_num(rt)) begin
            c = num_order(lt, lv, rt, rv);
            case (op)
               OP_LT:   res = c < 0;
               OP_GT:   res = c > 0;
               OP_LTE:  res = c <= 0;
               default: res = c >= 0;
            endcase
         end else f_type = 1'b1;
      end else if (op <= OP_NE) begin
         ok = 1'b1;
         same = 1'b0;
         if (is_num(lt) && is_num(rt)) same = num_order(lt, lv, rt, rv) == 0;
         else if ((lt == TY_STR && rt == TY_STR) || (lt == TY_BOOL && rt == TY_BOOL))
            same = lv == rv;
         else ok = 1'b0;
         if (ok) res = (op == OP_EQ) ? same : !same;
         else f_type = 1'b1;
      end else begin
         if (lt == TY_BOOL && rt == TY_BOOL)
            res = (op == OP_AND) ? (lv != 0 && rv != 0) : (lv != 0 || rv != 0);
         else f_type = 1'b1;
      end
      mdl_push(TY_BOOL, res ? 1 : 0);
   endfunction

   // advance the model by one token; returns 1 with the popped result on last
   function automatic bit expr_predict_step(logic [4:0] op, logic [2:0] otype, longint oval,
                                            bit last, output beat_type r);
      logic [2:0] lt, rt;
      longint     lv, rv;
      r = '0;
      if (op <= OP_OR) begin
         mdl_pop(rt, rv);
         mdl_pop(lt, lv);
         if (op <= OP_MOD) eval_arith(op, lt, lv, rt, rv);
         else eval_compare(op, lt, lv, rt, rv);
      end else if (op == OP_NEG) begin
         mdl_pop(lt, lv);
         if (lt == TY_INT) mdl_push(TY_INT, -lv);
         else if (lt == TY_REAL) mdl_push(TY_REAL, lv == SMIN ? SMAX : -lv);
         else begin f_type = 1'b1; mdl_push(TY_INT, 0); end
      end else if (op == OP_NOT) begin
         mdl_pop(lt, lv);
         if (lt == TY_BOOL) mdl_push(TY_BOOL, lv != 0 ? 0 : 1);
         else begin f_type = 1'b1; mdl_push(TY_BOOL, 0); end
      end else if (op == OP_LIT_BOOL) mdl_push(TY_BOOL, oval != 0 ? 1 : 0);
      else if (op == OP_LIT_INT) mdl_push(TY_INT, oval);
      else if (op == OP_LIT_REAL) mdl_push(TY_REAL, oval);
      else if (op == OP_LIT_STR) mdl_push(TY_STR, oval);
      else if (op <= OP_FIELD_RIGHT) begin
         if (otype == TY_NULL || otype > TY_STR) begin f_null = 1'b1; mdl_push(TY_NULL, 0); end
         else if (otype == TY_BOOL) mdl_push(TY_BOOL, oval != 0 ? 1 : 0);
         else mdl_push(otype, oval);
      end else if (op <= OP_RIGHT_END) mdl_push(TY_INT, oval);
      // spare opcodes fall through untouched

      if (!last) return 1'b0;
      mdl_pop(lt, lv);
      r.rtype    = lt;
      r.rvalue   = (lt == TY_NULL) ? 64'd0 : 64'(lv);
      r.type_err = f_type;
      r.div_zero = f_div0;
      r.null_op  = f_null;
      r.fault    = f_fault;
      {f_type, f_div0, f_null, f_fault} = '0;
      mdl_sp = 0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Token driver: predict, then hold the beat until the block takes it.
   // ---------------------------------------------------------------------
   task automatic send_token(logic [4:0] op, logic [2:0] otype, longint oval, bit last);
      beat_type r;
      int       gap;
      if (expr_predict_step(op, otype, oval, last, r)) pending_results.push_back(r);
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.opcode        <= op;
      req_if.operand_type  <= otype;
      req_if.operand_value <= 64'(oval);
      req_if.last_token    <= last;
      @(posedge clock iff req_if.ready);
   endtask

   function automatic longint pick_value();
      case ($urandom_range(0, 11))
         0:       return 0;
         1:       return 1;
         2:       return -1;
         3:       return SMAX;
         4:       return SMIN;
         5, 6:    return longint'($urandom_range(0, 200)) - 100;
         7, 8:    return (longint'($urandom_range(0, 2000)) - 1000) <<< 22;  // modest reals
         default: return longint'({$urandom, $urandom});
      endcase
   endfunction

   // push a random operand, mostly numeric so that operators see matching types
   task automatic send_operand(bit last);
      logic [4:0] op;
      logic [2:0] otype;
      otype = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
         0, 1, 2: op = OP_LIT_INT;
         3, 4:    op = OP_LIT_REAL;
         5:       op = OP_LIT_BOOL;
         6:       op = OP_LIT_STR;
         7: begin
            op = ($urandom_range(0, 1) != 0) ? OP_FIELD_LEFT : OP_FIELD_RIGHT;
            if ($urandom_range(0, 3) != 0) otype = ($urandom_range(0, 1) != 0) ? TY_INT : TY_REAL;
         end
         8:       op = ($urandom_range(0, 1) != 0) ? OP_FIELD_LEFT : OP_FIELD_RIGHT;
         default: op = 5'($urandom_range(OP_LEFT_BEGIN, OP_RIGHT_END));
      endcase
      send_token(op, otype, pick_value(), last);
   endtask

   // pick a binary operator that usually fits the two operands on top
   function automatic logic [4:0] pick_binary();
      logic [2:0] a, b;
      a = mdl_ty[mdl_sp - 1];
      b = mdl_ty[mdl_sp - 2];
      if ($urandom_range(0, 9) == 0) return 5'($urandom_range(OP_ADD, OP_OR));
      if (is_num(a) && is_num(b)) return 5'($urandom_range(OP_ADD, OP_NE));
      if (a == TY_BOOL && b == TY_BOOL) return 5'($urandom_range(OP_EQ, OP_OR));
      if (a == TY_STR && b == TY_STR) return ($urandom_range(0, 1) != 0) ? OP_EQ : OP_NE;
      return 5'($urandom_range(OP_ADD, OP_OR));
   endfunction

   // well-formed expression with random content; ends with the stack at one
   task automatic send_expression(output int count);
      int target, pushes;
      bit done;
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
      pushes = 0;
      count  = 0;
      done   = 1'b0;
      while (!done) begin
         if (mdl_sp >= 2 && ($urandom_range(0, 1) != 0 || pushes >= target)) begin
            done = (mdl_sp == 2 && pushes >= target);
            send_token(pick_binary(), TY_NULL, pick_value(), done);
         end else if (mdl_sp >= 1 && $urandom_range(0, 6) == 0) begin
            done = (mdl_sp == 1 && pushes >= target);
            send_token(($urandom_range(0, 1) != 0) ? OP_NEG : OP_NOT, TY_NULL, 0, done);
         end else begin
            pushes++;
            done = (mdl_sp == 0 && pushes >= target);
            send_operand(done);
         end
         count++;
      end
   endtask

   // malformed token run: any opcode, underflow, overflow, spare codes
   task automatic send_noise(output int count);
      int n;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 8);
      for (int k = 0; k < n; k++) begin
         if (n > 16 && $urandom_range(0, 4) != 0)
            send_operand(k == n - 1);
         else
            send_token(5'($urandom_range(0, OP_SPARE_HI)), 3'($urandom_range(0, 7)),
                       pick_value(), k == n - 1);
      end
      count = n;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, compare each beat with the oldest entry.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [63:0] expv, logic [63:0] actv);
      mismatch_count++;
      fail_seen = 1'b1;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %h actual %h at %0t", what, expv, actv, $realtime);
   endtask

   initial begin
      int       gap;
      beat_type got, want;
      rsp_if.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock iff rsp_if.valid);
         got = '{rsp_if.result_type, rsp_if.result_value, rsp_if.type_error,
                 rsp_if.divide_by_zero, rsp_if.null_operand, rsp_if.stack_fault};
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", '0, 64'(got.rtype));
            continue;
         end
         want = pending_results.pop_front();
         if (got.rtype !== want.rtype)
            report_mismatch("result_type", 64'(want.rtype), 64'(got.rtype));
         if (got.rvalue !== want.rvalue)
            report_mismatch("result_value", want.rvalue, got.rvalue);
         if (got.type_err !== want.type_err)
            report_mismatch("type_error", 64'(want.type_err), 64'(got.type_err));
         if (got.div_zero !== want.div_zero)
            report_mismatch("divide_by_zero", 64'(want.div_zero), 64'(got.div_zero));
         if (got.null_op !== want.null_op)
            report_mismatch("null_operand", 64'(want.null_op), 64'(got.null_op));
         if (got.fault !== want.fault)
            report_mismatch("stack_fault", 64'(want.fault), 64'(got.fault));
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      token_row_type rows[$];
      int            sent, n;

      req_if.valid         <= 1'b0;
      req_if.opcode        <= OP_ADD;
      req_if.operand_type  <= TY_NULL;
      req_if.operand_value <= '0;
      req_if.last_token    <= 1'b0;
      mdl_sp = 0;
      {f_type, f_div0, f_null, f_fault} = '0;
      mismatch_count = 0;
      fail_seen  = 1'b0;
      burst_mode = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed tokens. Rows marked typed carry a hand-written result.
      rows = '{
         // integer extremes straight through
         '{OP_LIT_INT,     TY_NULL, SMAX, 1, 1, '{TY_INT, 64'(SMAX), 0, 0, 0, 0}},
         '{OP_LIT_INT,     TY_NULL, SMIN, 1, 1, '{TY_INT, 64'(SMIN), 0, 0, 0, 0}},
         // boolean literal folds to one
         '{OP_LIT_BOOL,    TY_STR,  7,    1, 1, '{TY_BOOL, 64'd1, 0, 0, 0, 0}},
         // null field, and a field with a spare type code
         '{OP_FIELD_LEFT,  TY_NULL, 5,    1, 1, '{TY_NULL, 64'd0, 0, 0, 1, 0}},
         '{OP_FIELD_RIGHT, 3'd7,    -1,   1, 1, '{TY_NULL, 64'd0, 0, 0, 1, 0}},
         // operator on an empty stack: underflow plus a type error
         '{OP_ADD,         TY_NULL, 0,    1, 1, '{TY_INT, 64'd0, 1, 0, 0, 1}},
         // integer divide by zero
         '{OP_LIT_INT,     TY_NULL, 7,    0, 0, '{default: '0}},
         '{OP_LIT_INT,     TY_NULL, 0,    0, 0, '{default: '0}},
         '{OP_DIV,         TY_NULL, 0,    1, 1, '{TY_INT, 64'd0, 0, 1, 0, 0}},
         // remainder of min by minus one
         '{OP_LIT_INT,     TY_NULL, SMIN, 0, 0, '{default: '0}},
         '{OP_LIT_INT,     TY_NULL, -1,   0, 0, '{default: '0}},
         '{OP_MOD,         TY_NULL, 0,    1, 1, '{TY_INT, 64'd0, 0, 0, 0, 0}},
         // real times integer, exact
         '{OP_LIT_REAL,    TY_NULL, REAL_ONE_HALF, 0, 0, '{default: '0}},
         '{OP_LIT_INT,     TY_NULL, 3,    0, 0, '{default: '0}},
         '{OP_MUL,         TY_NULL, 0,    1, 0, '{default: '0}},
         // string ids compare equal
         '{OP_LIT_STR,     TY_NULL, 42,   0, 0, '{default: '0}},
         '{OP_FIELD_RIGHT, TY_STR,  42,   0, 0, '{default: '0}},
         '{OP_EQ,          TY_NULL, 0,    1, 1, '{TY_BOOL, 64'd1, 0, 0, 0, 0}},
         // negate a boolean: type error
         '{OP_LIT_BOOL,    TY_NULL, 0,    0, 0, '{default: '0}},
         '{OP_NOT,         TY_NULL, 0,    0, 0, '{default: '0}},
         '{OP_NEG,         TY_NULL, 0,    1, 1, '{TY_INT, 64'd0, 1, 0, 0, 0}},
         // spare opcode does nothing, interval time pushes an integer
         '{OP_SPARE_LO,    TY_NULL, 9,    0, 0, '{default: '0}},
         '{OP_LEFT_END,    TY_NULL, -5,   1, 1, '{TY_INT, 64'(-5), 0, 0, 0, 0}},
         // negating the most negative real saturates
         '{OP_LIT_REAL,    TY_NULL, SMIN, 0, 0, '{default: '0}},
         '{OP_NEG,         TY_NULL, 0,    1, 1, '{TY_REAL, 64'(SMAX), 0, 0, 0, 0}}
      };

      foreach (rows[i]) begin
         // typed rows replace the model's entry with the hand-written one
         if (rows[i].typed) begin
            send_token(rows[i].op, rows[i].otype, rows[i].oval, rows[i].last);
            void'(pending_results.pop_back());
            pending_results.push_back(rows[i].exp);
         end else
            send_token(rows[i].op, rows[i].otype, rows[i].oval, rows[i].last);
      end

      // Random expressions and noise runs; every so often switch to back-to-back beats.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) burst_mode = !burst_mode;
         if ($urandom_range(0, 9) == 0) send_noise(n);
         else send_expression(n);
         sent += n;
         // drain once mid-run so the block sees an empty pipe
         if (sent >= RANDOM_ITEMS / 2 && sent - n < RANDOM_ITEMS / 2) begin
            req_if.valid <= 1'b0;
            wait (pending_results.size() == 0);
            @(posedge clock);
         end
      end
      // close a noise tail that left tokens on the stack
      if (mdl_sp != 0) send_token(OP_LIT_INT, TY_NULL, 1, 1'b1);
      req_if.valid <= 1'b0;
      burst_mode = 1'b0;

      wait (pending_results.size() == 0);
      repeat (300) @(posedge clock);
      if (!fail_seen && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hang guard: far beyond the slowest legal run with divides and stalls
   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
